// File: src/prb_pkg.sv
`default_nettype none
package prb_pkg;

  localparam int DEPTH_DEF         = 32;
  localparam int PAYLOAD_WIDTH_DEF = 64;

  // Operation codes on the op field.
  localparam logic [2:0] OP_ADD        = 3'd0;
  localparam logic [2:0] OP_FLUSH      = 3'd1;
  localparam logic [2:0] OP_COUNT      = 3'd2;
  localparam logic [2:0] OP_FIRST_LOST = 3'd3;
  localparam logic [2:0] OP_NEXT_LOST  = 3'd4;

  // Status codes on the status field.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FLUSHED   = 3'd1;
  localparam logic [2:0] STAT_DUPLICATE = 3'd2;
  localparam logic [2:0] STAT_BEYOND    = 3'd3;
  localparam logic [2:0] STAT_ZERO_SEQ  = 3'd4;

  localparam logic [5:0] THRESHOLD_RESET = 6'd2;

  typedef enum logic [2:0] {
    KIND_ADD,
    KIND_FLUSH,
    KIND_COUNT,
    KIND_FIRST_LOST,
    KIND_NEXT_LOST,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] seq;
    logic [63:0] payload;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FLUSH_READ,
    BK_FLUSH_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// File: src/packet_reorder_buffer_core.sv
`default_nettype none
// Channel   Handshake            Payload
// in        in_valid/in_ready    op, seq, payload
// out       out_valid/out_ready  status, packet_valid, out_seq, out_payload,
//                                contiguous_count, span_count, last
// config    APB write/read       lost_threshold at byte address 0
//
// Add, count, lost queries and unknown ops each give one beat from the back end.
// A flush gives one beat per released packet, or a single empty beat when the
// head slot is empty. Once the flush is taken from the queue, each packet beat
// passes a read state, for the registered read of the payload memory at the head slot, then an emit state.
// Reset is synchronous and empties the buffer at once; no clearing pass runs.
// A two-entry queue keeps taking beats while the output register is stalled, until it is full.
module packet_reorder_buffer_core import prb_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] seq,
  input  wire logic [63:0] payload,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic             packet_valid,
  output logic [31:0]      out_seq,
  output logic [63:0]      out_payload,
  output logic [5:0]       contiguous_count,
  output logic [5:0]       span_count,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // The loss threshold is the only register; it sits at byte address zero.
  logic [5:0] lost_threshold;
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {26'd0, lost_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lost_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      lost_threshold <= pwdata[5:0];
    end
  end

  // The front end takes beats, decodes their operation and queues them in order.
  prb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .seq      (seq),
    .payload  (payload),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // The back end owns the ring, the head pointers and the output register.
  prb_back #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .threshold        (lost_threshold),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .packet_valid     (packet_valid),
    .out_seq          (out_seq),
    .out_payload      (out_payload),
    .contiguous_count (contiguous_count),
    .span_count       (span_count),
    .last             (last)
  );

endmodule
`default_nettype wire

// File: src/prb_front.sv
`default_nettype none
module prb_front import prb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] seq,
  input  wire logic [63:0] payload,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  kind_t      kind;

  always_comb begin
    case (op)
      OP_ADD:        kind = KIND_ADD;
      OP_FLUSH:      kind = KIND_FLUSH;
      OP_COUNT:      kind = KIND_COUNT;
      OP_FIRST_LOST: kind = KIND_FIRST_LOST;
      OP_NEXT_LOST:  kind = KIND_NEXT_LOST;
      default:       kind = KIND_NONE;
    endcase
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= '{kind: kind, seq: seq, payload: payload};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

// File: src/prb_back.sv
`default_nettype none
module prb_back import prb_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [5:0]  threshold,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic             packet_valid,
  output logic [31:0]      out_seq,
  output logic [63:0]      out_payload,
  output logic [5:0]       contiguous_count,
  output logic [5:0]       span_count,
  output logic             last
);

  localparam int SW  = $clog2(DEPTH);
  localparam int SW1 = SW + 1;
  localparam int CW  = $clog2(DEPTH + 1);

  back_state_t state, state_next;

  logic [DEPTH-1:0]         slot_full, slot_full_next;
  logic [SW-1:0]            head_slot, head_slot_next;
  logic [31:0]              head_seq, head_seq_next;
  logic [31:0]              newest, newest_next;
  logic [31:0]              last_req, last_req_next;
  logic [CW-1:0]            flush_n, flush_n_next;

  logic [PAYLOAD_WIDTH-1:0] slot_mem [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] rd_data;
  logic                     mem_we;
  logic [SW-1:0]            mem_waddr;

  logic        out_free;
  logic        load;
  logic [2:0]  b_status;
  logic        b_pvalid;
  logic [31:0] b_seq;
  logic [63:0] b_payload;
  logic [5:0]  b_cc;
  logic [5:0]  b_sc;
  logic        b_last;

  logic [DEPTH-1:0] rot;
  logic [SW1-1:0]   idx_sum;
  logic [CW-1:0]    contig;
  logic [31:0]      span;
  logic [SW-1:0]    next_slot;
  logic             flush_last;

  // Add decode.
  logic [31:0]   add_off;
  logic          add_beyond;
  logic [SW1-1:0] add_sum;
  logic [SW-1:0] add_idx;

  // Lost scan.
  logic [31:0]   lr_eff;
  logic [31:0]   lr_base;
  logic [31:0]   scan_off;
  logic [31:0]   scan_lim;
  logic          scan_pass;
  logic          scan_hit;
  logic [SW-1:0] scan_k;

  assign out_free = !out_valid || out_ready;

  // Occupancy bits rotated so that bit k is the slot k places after the head.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      idx_sum = {1'b0, head_slot} + SW1'(k);
      if (idx_sum >= SW1'(DEPTH)) idx_sum = idx_sum - SW1'(DEPTH);
      rot[k] = slot_full[idx_sum[SW-1:0]];
    end
  end

  always_comb begin
    contig = CW'(DEPTH);
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (!rot[k]) contig = CW'(k);
    end
  end

  assign span = (newest == 32'd0) ? 32'd0 : (newest - head_seq + 32'd1);

  always_comb begin
    if (head_slot == SW'(DEPTH - 1)) next_slot = '0;
    else next_slot = head_slot + SW'(1);
  end

  assign flush_last = (flush_n == CW'(DEPTH - 1)) || !slot_full[next_slot];

  always_comb begin
    add_off    = q_item.seq - head_seq;
    add_beyond = ({1'b0, q_item.seq} >= ({1'b0, head_seq} + 33'(DEPTH)));
    add_sum    = {1'b0, head_slot} + {1'b0, add_off[SW-1:0]};
    if (add_sum >= SW1'(DEPTH)) add_sum = add_sum - SW1'(DEPTH);
    add_idx    = add_sum[SW-1:0];
  end

  always_comb begin
    lr_eff    = (q_item.kind == KIND_FIRST_LOST) ? 32'd0 : last_req;
    scan_pass = (span > 32'(threshold)) && (lr_eff < (newest - 32'(threshold)));
    lr_base   = (lr_eff < head_seq) ? 32'd0 : lr_eff;
    scan_off  = (lr_base == 32'd0) ? 32'd0 : (lr_base - head_seq + 32'd1);
    scan_lim  = span - 32'(threshold);
    scan_hit  = 1'b0;
    scan_k    = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (!rot[k] && (32'(k) >= scan_off) && (32'(k) < scan_lim)) begin
        scan_hit = 1'b1;
        scan_k   = SW'(k);
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid && out_free && q_item.kind == KIND_FLUSH && rot[0]) begin
          state_next = BK_FLUSH_READ;
        end
      end
      BK_FLUSH_READ: state_next = BK_FLUSH_EMIT;
      BK_FLUSH_EMIT: begin
        if (out_free) state_next = flush_last ? BK_IDLE : BK_FLUSH_READ;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs and buffer state updates.
  always_comb begin
    q_pop          = 1'b0;
    load           = 1'b0;
    b_status       = STAT_OK;
    b_pvalid       = 1'b0;
    b_seq          = '0;
    b_payload      = '0;
    b_cc           = '0;
    b_sc           = '0;
    b_last         = 1'b1;
    slot_full_next = slot_full;
    head_slot_next = head_slot;
    head_seq_next  = head_seq;
    newest_next    = newest;
    last_req_next  = last_req;
    flush_n_next   = flush_n;
    mem_we         = 1'b0;
    mem_waddr      = add_idx;
    case (state)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_item.kind)
            KIND_ADD: begin
              load = 1'b1;
              if (q_item.seq == 32'd0) begin
                b_status = STAT_ZERO_SEQ;
              end else if (q_item.seq < head_seq) begin
                b_status = STAT_FLUSHED;
              end else if (add_beyond) begin
                b_status = STAT_BEYOND;
              end else if (slot_full[add_idx]) begin
                b_status = STAT_DUPLICATE;
              end else begin
                mem_we                  = 1'b1;
                slot_full_next[add_idx] = 1'b1;
                if (q_item.seq > newest) newest_next = q_item.seq;
              end
            end
            KIND_FLUSH: begin
              flush_n_next = '0;
              load         = !rot[0];
            end
            KIND_COUNT: begin
              load = 1'b1;
              b_cc = 6'(contig);
              b_sc = span[5:0];
            end
            KIND_FIRST_LOST, KIND_NEXT_LOST: begin
              load          = 1'b1;
              last_req_next = lr_eff;
              if (scan_pass) begin
                last_req_next = lr_base;
                if (scan_hit) begin
                  b_seq         = head_seq + 32'(scan_k);
                  last_req_next = b_seq;
                end
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      BK_FLUSH_EMIT: begin
        if (out_free) begin
          load                      = 1'b1;
          b_pvalid                  = 1'b1;
          b_seq                     = head_seq;
          b_payload                 = 64'(rd_data);
          b_last                    = flush_last;
          slot_full_next[head_slot] = 1'b0;
          head_slot_next            = next_slot;
          head_seq_next             = head_seq + 32'd1;
          if (newest < head_seq_next) newest_next = 32'd0;
          flush_n_next              = flush_n + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= q_item.payload[PAYLOAD_WIDTH-1:0];
    rd_data <= slot_mem[head_slot];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status           <= b_status;
      packet_valid     <= b_pvalid;
      out_seq          <= b_seq;
      out_payload      <= b_payload;
      contiguous_count <= b_cc;
      span_count       <= b_sc;
      last             <= b_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      slot_full <= '0;
      head_slot <= '0;
      head_seq  <= 32'd1;
      newest    <= 32'd0;
      last_req  <= 32'd0;
      flush_n   <= '0;
    end else begin
      state     <= state_next;
      out_valid <= load || (out_valid && !out_ready);
      slot_full <= slot_full_next;
      head_slot <= head_slot_next;
      head_seq  <= head_seq_next;
      newest    <= newest_next;
      last_req  <= last_req_next;
      flush_n   <= flush_n_next;
    end
  end

endmodule
`default_nettype wire
